// ===== rtl/pprt_pkg.sv =====
package pprt_pkg;

    localparam int CoordW = 32;
    localparam int AxisW  = 16;
    localparam int RegW   = 48;
    localparam int QuoW   = 32;
    localparam int RemW   = 48;
    localparam int Lanes  = 6;

    localparam logic [2:0] CFG_AXIS0  = 3'd0;
    localparam logic [2:0] CFG_AXIS1  = 3'd1;
    localparam logic [2:0] CFG_AXIS2  = 3'd2;
    localparam logic [2:0] CFG_SCALE  = 3'd3;
    localparam logic [2:0] CFG_ORIG_X = 3'd4;
    localparam logic [2:0] CFG_ORIG_Y = 3'd5;
    localparam logic [2:0] CFG_ORIG_Z = 3'd6;

    localparam logic OP_TO_WORLD = 1'b0;
    localparam logic OP_TO_LOCAL = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_point_x;
        logic signed [31:0] out_point_y;
        logic signed [31:0] out_point_z;
        logic signed [31:0] out_dir_x;
        logic signed [31:0] out_dir_y;
        logic signed [31:0] out_dir_z;
        logic               saturated;
    } out_item_t;

    // One output component on its way through the divider.
    typedef struct packed {
        logic              to_world;
        logic              sat;
        logic              zero_scale;
        logic              dot_pos;
        logic              dot_neg;
        logic              neg;
        logic              big;
        logic [15:0]       sc;
        logic [RemW-1:0]   rem;
        logic [QuoW-1:0]   quo;
    } div_lane_t;

endpackage

// ===== rtl/pprt_div.sv =====
module pprt_div (
    input  logic                               clk,
    input  logic [pprt_pkg::QuoW-1:0]          en,
    input  pprt_pkg::div_lane_t                lane_in,
    output pprt_pkg::div_lane_t                lane_out
);

    pprt_pkg::div_lane_t stage_reg [pprt_pkg::QuoW];
    pprt_pkg::div_lane_t stage_next [pprt_pkg::QuoW];

    for (genvar k = 0; k < pprt_pkg::QuoW; k++) begin : g_step
        localparam int B = pprt_pkg::QuoW - 1 - k;

        always_comb
        begin
            pprt_pkg::div_lane_t src;
            logic [pprt_pkg::RemW-1:0] trial;
            src   = (k == 0) ? lane_in : stage_reg[(k == 0) ? 0 : k - 1];
            trial = {{(pprt_pkg::RemW - 16){1'b0}}, src.sc} << B;
            stage_next[k] = src;
            // restoring step: one quotient bit
            if (!src.to_world && (src.rem >= trial))
            begin
                stage_next[k].rem    = src.rem - trial;
                stage_next[k].quo[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign lane_out = stage_reg[pprt_pkg::QuoW - 1];

endmodule

// ===== rtl/pose_point_ray_transform_top.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------
// in       | in_valid / in_ready       | in_data  (in_item_t)
// out      | out_valid / out_ready     | out_data (out_item_t)
// cfg      | cfg_we                    | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high. The path is four
// arithmetic stages, 32 steps of the restoring divider (one quotient bit per stage) and
// the output register. rst_n clears valid bits and loads the identity frame.
// Each stage holds while it is full and the next one holds; empty stages fill
// behind a stalled output, so nothing is lost or repeated.
module pose_point_ray_transform_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pprt_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pprt_pkg::out_item_t   out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [47:0]           cfg_data
);

    localparam int NS   = 4 + pprt_pkg::QuoW + 1;
    localparam int LAST = NS - 1;

    logic [47:0]        axis_reg [3];
    logic [47:0]        scale_reg;
    logic signed [31:0] origin_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg[0]   <= 48'h0000_0000_4000;
            axis_reg[1]   <= 48'h0000_4000_0000;
            axis_reg[2]   <= 48'h4000_0000_0000;
            scale_reg     <= 48'h0100_0100_0100;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pprt_pkg::CFG_AXIS0:  axis_reg[0]   <= cfg_data;
                pprt_pkg::CFG_AXIS1:  axis_reg[1]   <= cfg_data;
                pprt_pkg::CFG_AXIS2:  axis_reg[2]   <= cfg_data;
                pprt_pkg::CFG_SCALE:  scale_reg     <= cfg_data;
                pprt_pkg::CFG_ORIG_X: origin_reg[0] <= cfg_data[31:0];
                pprt_pkg::CFG_ORIG_Y: origin_reg[1] <= cfg_data[31:0];
                pprt_pkg::CFG_ORIG_Z: origin_reg[2] <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // stage enables: advance when empty or when the next stage advances
    logic [NS:0]   en;
    logic [NS-1:0] vld_reg;

    assign en[NS] = out_ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k + 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[LAST];

    // stage 1: scale (to world) or subtract origin from the points (to local)
    logic signed [31:0] vin [6];
    logic signed [40:0] a_next [6];
    logic signed [40:0] a_reg  [6];
    logic               op1_reg;

    assign vin[0] = in_data.point_x;
    assign vin[1] = in_data.point_y;
    assign vin[2] = in_data.point_z;
    assign vin[3] = in_data.dir_x;
    assign vin[4] = in_data.dir_y;
    assign vin[5] = in_data.dir_z;

    always_comb
    begin
        logic signed [48:0] m;
        logic signed [48:0] mr;
        logic signed [32:0] d;
        for (int l = 0; l < 6; l++)
        begin
            m  = vin[l] * $signed({1'b0, scale_reg[16 * (l % 3) +: 16]});
            mr = m + 49'sd128;
            if (l < 3)
            begin
                d = {vin[l][31], vin[l]} - {origin_reg[l % 3][31], origin_reg[l % 3]};
            end
            else
            begin
                d = {vin[l][31], vin[l]};
            end
            if (in_data.op == pprt_pkg::OP_TO_WORLD)
            begin
                a_next[l] = mr[48:8];
            end
            else
            begin
                a_next[l] = {{8{d[32]}}, d};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg   <= a_next;
            op1_reg <= in_data.op;
        end
    end

    // stage 2: nine products per vector
    logic signed [56:0] prod_next [6][3];
    logic signed [56:0] prod_reg  [6][3];
    logic               op2_reg;

    always_comb
    begin
        logic signed [15:0] coef;
        int c;
        int base;
        for (int l = 0; l < 6; l++)
        begin
            c    = l % 3;
            base = (l < 3) ? 0 : 3;
            for (int i = 0; i < 3; i++)
            begin
                if (op1_reg == pprt_pkg::OP_TO_WORLD)
                begin
                    coef = axis_reg[i][16 * c +: 16];
                end
                else
                begin
                    coef = axis_reg[c][16 * i +: 16];
                end
                prod_next[l][i] = a_reg[base + i] * coef;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg <= prod_next;
            op2_reg  <= op1_reg;
        end
    end

    // stage 3: sum
    logic signed [58:0] sum_reg [6];
    logic               op3_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int l = 0; l < 6; l++)
            begin
                sum_reg[l] <= {{2{prod_reg[l][0][56]}}, prod_reg[l][0]}
                            + {{2{prod_reg[l][1][56]}}, prod_reg[l][1]}
                            + {{2{prod_reg[l][2][56]}}, prod_reg[l][2]};
            end
            op3_reg <= op2_reg;
        end
    end

    // stage 4: round and clip (to world), or set up the division (to local)
    pprt_pkg::div_lane_t lane_next [6];
    pprt_pkg::div_lane_t lane_reg  [6];

    always_comb
    begin
        logic signed [58:0] tr;
        logic signed [45:0] r;
        logic               ovf;
        logic [15:0]        sc;
        logic [59:0]        mq;
        logic [53:0]        mv;
        logic [55:0]        u;
        for (int l = 0; l < 6; l++)
        begin
            sc = scale_reg[16 * (l % 3) +: 16];
            tr = sum_reg[l] + 59'sd8192;
            r  = {tr[58], tr[58:14]};
            if (l < 3)
            begin
                r = r + {{14{origin_reg[l % 3][31]}}, origin_reg[l % 3]};
            end
            ovf = !((&r[45:31]) || !(|r[45:31]));

            // floor((q + 32*sc) / 64), then fold the sign for unsigned division
            mq = {sum_reg[l][58], sum_reg[l]} + {39'd0, sc, 5'd0};
            mv = mq[59:6];
            if (mv[53])
            begin
                u = {40'd0, sc} - 56'd1 - {{2{mv[53]}}, mv};
            end
            else
            begin
                u = {{2{1'b0}}, mv};
            end

            lane_next[l].to_world   = (op3_reg == pprt_pkg::OP_TO_WORLD);
            lane_next[l].zero_scale = (sc == 16'd0);
            lane_next[l].dot_pos    = !sum_reg[l][58] && (sum_reg[l] != '0);
            lane_next[l].dot_neg    = sum_reg[l][58];
            lane_next[l].neg        = mv[53];
            lane_next[l].big        = u[54:0] >= {7'd0, sc, 32'd0};
            lane_next[l].sc         = sc;
            lane_next[l].rem        = u[47:0];
            if (op3_reg == pprt_pkg::OP_TO_WORLD)
            begin
                lane_next[l].sat = ovf;
                if (ovf)
                begin
                    lane_next[l].quo = r[45] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                else
                begin
                    lane_next[l].quo = r[31:0];
                end
            end
            else
            begin
                lane_next[l].sat = 1'b0;
                lane_next[l].quo = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            lane_reg <= lane_next;
        end
    end

    pprt_pkg::div_lane_t div_out [6];

    for (genvar l = 0; l < 6; l++) begin : g_div
        pprt_div u_div (
            .clk      (clk),
            .en       (en[4 +: pprt_pkg::QuoW]),
            .lane_in  (lane_reg[l]),
            .lane_out (div_out[l])
        );
    end

    // final: sign, clip and special cases
    logic [31:0]          res [6];
    logic                 flag;
    pprt_pkg::out_item_t  out_next;
    pprt_pkg::out_item_t  out_reg;

    always_comb
    begin
        flag = 1'b0;
        for (int l = 0; l < 6; l++)
        begin
            if (div_out[l].to_world)
            begin
                res[l] = div_out[l].quo;
                flag   = flag | div_out[l].sat;
            end
            else if (div_out[l].zero_scale)
            begin
                flag = 1'b1;
                if (div_out[l].dot_pos)
                begin
                    res[l] = 32'h7FFF_FFFF;
                end
                else if (div_out[l].dot_neg)
                begin
                    res[l] = 32'h8000_0000;
                end
                else
                begin
                    res[l] = '0;
                end
            end
            else if (div_out[l].big)
            begin
                flag   = 1'b1;
                res[l] = div_out[l].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (div_out[l].neg)
            begin
                if (div_out[l].quo > 32'h8000_0000)
                begin
                    flag   = 1'b1;
                    res[l] = 32'h8000_0000;
                end
                else
                begin
                    res[l] = 32'd0 - div_out[l].quo;
                end
            end
            else if (div_out[l].quo[31])
            begin
                flag   = 1'b1;
                res[l] = 32'h7FFF_FFFF;
            end
            else
            begin
                res[l] = div_out[l].quo;
            end
        end
        out_next.out_point_x = res[0];
        out_next.out_point_y = res[1];
        out_next.out_point_z = res[2];
        out_next.out_dir_x   = res[3];
        out_next.out_dir_y   = res[4];
        out_next.out_dir_z   = res[5];
        out_next.saturated   = flag;
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/pprt_checker.sv =====
module pprt_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input pprt_pkg::in_item_t    in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input pprt_pkg::out_item_t   out_data,
    input logic                  cfg_we,
    input logic [2:0]            cfg_index,
    input logic [47:0]           cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // an open output never backs up the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is open");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

endmodule

bind pose_point_ray_transform_top pprt_checker u_pprt_checker (.*);

// ===== dv/pprt_checker.sv =====
`timescale 1ns / 1ps

module pprt_tb_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  pprt_pkg::in_item_t    in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  pprt_pkg::out_item_t   out_data,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [47:0]           cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    rays_seen,
    output int                    sat_seen
);

    logic [47:0]          axis_q [3];
    logic [47:0]          scale_q;
    longint               origin_q [3];
    pprt_pkg::out_item_t  expected_rays [$];

    function automatic longint axis_at(int row, int c);
        logic signed [15:0] a;
        a = axis_q[row][16*c +: 16];
        return longint'(a);
    endfunction

    function automatic longint scale_at(int c);
        return longint'({48'd0, scale_q[16*c +: 16]});
    endfunction

    // round half up of n / d, d > 0
    function automatic longint round_half_up(longint n, longint d);
        longint nn, dd, q;
        nn = 2 * n + d;
        dd = 2 * d;
        q = nn / dd;
        if ((nn % dd) != 0 && nn < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] clamp32(longint v, ref logic flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic void rotate_out(longint v[3], logic with_origin,
                                       ref logic [31:0] r[3], ref logic flag);
        longint s[3];
        longint t, x;
        for (int i = 0; i < 3; i++)
            s[i] = round_half_up(v[i] * scale_at(i), 256);
        for (int c = 0; c < 3; c++)
        begin
            t = 0;
            for (int i = 0; i < 3; i++)
                t += s[i] * axis_at(i, c);
            x = round_half_up(t, 16384);
            if (with_origin)
                x += origin_q[c];
            r[c] = clamp32(x, flag);
        end
    endfunction

    function automatic void rotate_in(longint v[3], logic with_origin,
                                      ref logic [31:0] r[3], ref logic flag);
        longint d[3];
        longint q, sc;
        for (int i = 0; i < 3; i++)
            d[i] = with_origin ? v[i] - origin_q[i] : v[i];
        for (int j = 0; j < 3; j++)
        begin
            q = 0;
            sc = scale_at(j);
            for (int i = 0; i < 3; i++)
                q += d[i] * axis_at(j, i);
            if (sc == 0)
            begin
                flag = 1'b1;
                r[j] = q > 0 ? 32'h7fffffff : (q < 0 ? 32'h80000000 : 32'h0);
            end
            else
                r[j] = clamp32(round_half_up(q, sc * 64), flag);
        end
    endfunction

    function automatic pprt_pkg::out_item_t transform_ray(pprt_pkg::in_item_t it);
        longint p[3], v[3];
        logic [31:0] rp[3], rv[3];
        logic flag;
        pprt_pkg::out_item_t o;
        flag = 1'b0;
        p = '{longint'(it.point_x), longint'(it.point_y), longint'(it.point_z)};
        v = '{longint'(it.dir_x), longint'(it.dir_y), longint'(it.dir_z)};
        if (it.op == pprt_pkg::OP_TO_WORLD)
        begin
            rotate_out(p, 1'b1, rp, flag);
            rotate_out(v, 1'b0, rv, flag);
        end
        else
        begin
            rotate_in(p, 1'b1, rp, flag);
            rotate_in(v, 1'b0, rv, flag);
        end
        o.out_point_x = rp[0];
        o.out_point_y = rp[1];
        o.out_point_z = rp[2];
        o.out_dir_x   = rv[0];
        o.out_dir_y   = rv[1];
        o.out_dir_z   = rv[2];
        o.saturated   = flag;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pprt_pkg::out_item_t e;
        if (!rst_n)
        begin
            axis_q[0] = 48'd16384;
            axis_q[1] = 48'd16384 << 16;
            axis_q[2] = 48'd16384 << 32;
            scale_q = {16'd256, 16'd256, 16'd256};
            origin_q = '{0, 0, 0};
            expected_rays.delete();
            fail_count = 0;
            rays_seen = 0;
            sat_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pprt_pkg::CFG_AXIS0:  axis_q[0] = cfg_data;
                    pprt_pkg::CFG_AXIS1:  axis_q[1] = cfg_data;
                    pprt_pkg::CFG_AXIS2:  axis_q[2] = cfg_data;
                    pprt_pkg::CFG_SCALE:  scale_q = cfg_data;
                    pprt_pkg::CFG_ORIG_X: origin_q[0] = longint'($signed(cfg_data[31:0]));
                    pprt_pkg::CFG_ORIG_Y: origin_q[1] = longint'($signed(cfg_data[31:0]));
                    pprt_pkg::CFG_ORIG_Z: origin_q[2] = longint'($signed(cfg_data[31:0]));
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_rays.push_back(transform_ray(in_data));
            if (out_valid && out_ready)
            begin
                rays_seen++;
                if (out_data.saturated)
                    sat_seen++;
                if (expected_rays.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end
                else
                begin
                    e = expected_rays.pop_front();
                    if (out_data.out_point_x !== e.out_point_x)
                        report_mismatch("out_point_x", out_data.out_point_x, e.out_point_x);
                    if (out_data.out_point_y !== e.out_point_y)
                        report_mismatch("out_point_y", out_data.out_point_y, e.out_point_y);
                    if (out_data.out_point_z !== e.out_point_z)
                        report_mismatch("out_point_z", out_data.out_point_z, e.out_point_z);
                    if (out_data.out_dir_x !== e.out_dir_x)
                        report_mismatch("out_dir_x", out_data.out_dir_x, e.out_dir_x);
                    if (out_data.out_dir_y !== e.out_dir_y)
                        report_mismatch("out_dir_y", out_data.out_dir_y, e.out_dir_y);
                    if (out_data.out_dir_z !== e.out_dir_z)
                        report_mismatch("out_dir_z", out_data.out_dir_z, e.out_dir_z);
                    if (out_data.saturated !== e.saturated)
                        report_mismatch("saturated", 32'(out_data.saturated),
                                        32'(e.saturated));
                end
            end
            pending = expected_rays.size();
        end
    end

endmodule

// ===== dv/pose_point_ray_transform_top_tb.sv =====
`timescale 1ns / 1ps

module pose_point_ray_transform_top_tb;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pprt_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_ready;
    pprt_pkg::out_item_t  out_data;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [47:0]          cfg_data;
    int                   fail_count;
    int                   pending;
    int                   rays_seen;
    int                   sat_seen;
    int                   stall_mode;

    pose_point_ray_transform_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pprt_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .rays_seen  (rays_seen),
        .sat_seen   (sat_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall pattern, switched between phases
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 19) != 0) ? out_ready : ~out_ready;
        endcase
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff);
        endcase
    endfunction

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h4000;
            3: return 16'hc000;
            default: return 16'($urandom());
        endcase
    endfunction

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic send_ray(logic op, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        in_valid <= 1'b1;
        in_data  <= '{op, px, py, pz, dx, dy, dz};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_ray();
        send_ray(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let the pipeline settle before touching registers
        repeat (45) @(posedge clk);
    endtask

    task automatic random_frame(int flavor);
        logic [47:0] sc;
        write_reg(pprt_pkg::CFG_AXIS0, {pick_axis(), pick_axis(), pick_axis()});
        write_reg(pprt_pkg::CFG_AXIS1, {pick_axis(), pick_axis(), pick_axis()});
        write_reg(pprt_pkg::CFG_AXIS2, {pick_axis(), pick_axis(), pick_axis()});
        case (flavor)
            0: sc = 48'hffff_ffff_ffff;
            1: sc = {16'd0, 16'($urandom_range(1, 1024)), 16'd0};
            2: sc = {16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)),
                     16'($urandom_range(1, 1024))};
            default: sc = 48'({$urandom(), $urandom()});
        endcase
        write_reg(pprt_pkg::CFG_SCALE, sc);
        write_reg(pprt_pkg::CFG_ORIG_X, {16'd0, pick_coord()});
        write_reg(pprt_pkg::CFG_ORIG_Y, {16'd0, pick_coord()});
        write_reg(pprt_pkg::CFG_ORIG_Z, {16'd0, pick_coord()});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = pprt_pkg::CFG_AXIS0;
        cfg_data   = '0;
        out_ready  = 1'b0;
        stall_mode = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity frame, extremes and both directions
        send_ray(pprt_pkg::OP_TO_WORLD, 0, 0, 0, 0, 0, 0);
        send_ray(pprt_pkg::OP_TO_LOCAL, 0, 0, 0, 0, 0, 0);
        send_ray(pprt_pkg::OP_TO_WORLD, 32'h7fffffff, 32'h80000000, 32'h00010000,
                 32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'h7fffffff, 32'h80000000, 32'h00010000,
                 32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_ray(pprt_pkg::OP_TO_WORLD, 32'hffffffff, 1, 32'h55555555, 32'haaaaaaaa, 7,
                 32'hfffffff9);
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'haaaaaaaa, 32'h55555555, 1, 0, 32'h80000000,
                 32'h7fffffff);
        drain();

        // extreme frame: full axes, max scale, far origin
        write_reg(pprt_pkg::CFG_AXIS0, 48'h7fff_7fff_7fff);
        write_reg(pprt_pkg::CFG_AXIS1, 48'h8000_8000_8000);
        write_reg(pprt_pkg::CFG_AXIS2, 48'h8000_7fff_0000);
        write_reg(pprt_pkg::CFG_SCALE, 48'hffff_ffff_ffff);
        write_reg(pprt_pkg::CFG_ORIG_X, {16'd0, 32'h7fffffff});
        write_reg(pprt_pkg::CFG_ORIG_Y, {16'd0, 32'h80000000});
        write_reg(pprt_pkg::CFG_ORIG_Z, {16'd0, 32'h00000001});
        cfg_we <= 1'b0;
        stall_mode = 1;
        send_ray(pprt_pkg::OP_TO_WORLD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 2, 3);
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'h7fffffff, 32'h80000000, 0, 32'h80000000, 0, 0);
        send_ray(pprt_pkg::OP_TO_WORLD, 32'h00000100, 32'hffffff00, 0, 0, 0, 0);
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'h80000000, 32'h7fffffff, 5, 1, 1, 1);
        drain();

        // zero scale: local-to-world multiplies by zero, world-to-local flags
        write_reg(pprt_pkg::CFG_SCALE, 48'h0);
        write_reg(pprt_pkg::CFG_ORIG_X, 48'h0);
        write_reg(pprt_pkg::CFG_ORIG_Y, 48'h0);
        write_reg(pprt_pkg::CFG_ORIG_Z, 48'h0);
        cfg_we <= 1'b0;
        send_ray(pprt_pkg::OP_TO_WORLD, 32'h00010000, 32'h00010000, 32'h00010000, 1, 1, 1);
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'h00010000, 32'hffff0000, 0, 0, 0, 0);
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'hffff0000, 32'h00010000, 32'h00010000,
                 32'h80000000, 0, 0);
        send_ray(pprt_pkg::OP_TO_LOCAL, 0, 0, 0, 0, 0, 0);
        drain();

        // minimum nonzero scale
        write_reg(pprt_pkg::CFG_SCALE, 48'h0001_0001_0001);
        cfg_we <= 1'b0;
        send_ray(pprt_pkg::OP_TO_LOCAL, 32'h7fffffff, 3, 32'h80000000, 1, 32'hffffffff, 2);
        send_ray(pprt_pkg::OP_TO_WORLD, 32'h7fffffff, 3, 32'h80000000, 1, 32'hffffffff, 2);
        send_ray(pprt_pkg::OP_TO_LOCAL, 1, 0, 0, 0, 0, 32'hffffffff);
        drain();

        // random phases, each with a new frame and one of four stall patterns
        for (int phase = 0; phase < 8; phase++)
        begin
            random_frame(phase % 4);
            stall_mode = phase % 4;
            for (int n = 0; n < 105; )
            begin
                int   burst;
                int   gap;
                logic hold;
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && n < 105; k++, n++)
                    send_random_ray();
                gap  = $urandom_range(0, 6);
                hold = (phase == 3 && n >= 50 && n < 75);
                if (gap != 0 || hold)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                    if (hold)
                    begin
                        // hold the sender until everything has come out
                        @(posedge clk);
                        while (pending != 0)
                            @(posedge clk);
                    end
                end
            end
            drain();
        end

        $display("tb: %0d rays checked, %0d saturated, over 12 frames and 4 stall patterns",
                 rays_seen, sat_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
